### hw/rtl/tsct_pkg.sv
// ----------------------------------------------------------------------------
// Touch strip contact tracker package
// Shared constants, beat types and run state type for the contact tracker.
// ----------------------------------------------------------------------------
package tsct_pkg;

    // Number of physical pads on the strip.
    localparam int NUM_PADS = 32;

    // Field widths.
    localparam int PAD_W   = 5;
    localparam int COUNT_W = 2;

    // Event operation codes.
    localparam logic OP_TOUCH   = 1'b0;
    localparam logic OP_RELEASE = 1'b1;

    // Run length codes.
    localparam logic [COUNT_W-1:0] RUN_EMPTY  = 2'd0;
    localparam logic [COUNT_W-1:0] RUN_SINGLE = 2'd1;
    localparam logic [COUNT_W-1:0] RUN_DOUBLE = 2'd2;
    localparam logic [COUNT_W-1:0] RUN_TRIPLE = 2'd3;

    typedef logic [PAD_W-1:0] pad_t;

    // Input beat: one touch or release event.
    typedef struct packed {
        logic operation;
        pad_t pad_index;
    } in_beat_t;

    // Result beat: interpolated position and run size.
    typedef struct packed {
        pad_t               position;
        logic               position_valid;
        logic [COUNT_W-1:0] contact_count;
    } out_beat_t;

    // Tracked run of adjacent pads.
    typedef struct packed {
        logic [COUNT_W-1:0] run_length;
        pad_t               left_pad;
        pad_t               middle_pad;
        pad_t               right_pad;
    } run_t;

endpackage

### hw/rtl/tsct_update.sv
// ----------------------------------------------------------------------------
// Contact tracker run update
// Computes the next run state from one event and the result beat that
// reports the run after that event.
// ----------------------------------------------------------------------------
module tsct_update (
    input  tsct_pkg::in_beat_t  event_beat,
    input  tsct_pkg::run_t      run_cur,
    output tsct_pkg::run_t      run_next,
    output tsct_pkg::out_beat_t result
);

    // One extra bit keeps the neighbor compares free of wraparound.
    logic [tsct_pkg::PAD_W:0] pad_ext;
    logic [tsct_pkg::PAD_W:0] left_ext;
    logic [tsct_pkg::PAD_W:0] right_ext;
    logic                     in_range;
    logic                     left_adj;
    logic                     right_adj;
    logic [tsct_pkg::PAD_W:0] pair_sum;

    assign pad_ext   = {1'b0, event_beat.pad_index};
    assign left_ext  = {1'b0, run_cur.left_pad};
    assign right_ext = {1'b0, run_cur.right_pad};
    assign in_range  = (32'(event_beat.pad_index) < tsct_pkg::NUM_PADS);
    assign left_adj  = ((pad_ext + 1'b1) == left_ext);
    assign right_adj = (pad_ext == (right_ext + 1'b1));

    // Next run state.
    always_comb begin
        run_next = run_cur;
        if (in_range) begin
            if (event_beat.operation == tsct_pkg::OP_TOUCH) begin
                case (run_cur.run_length)
                    tsct_pkg::RUN_EMPTY: begin
                        run_next.left_pad   = event_beat.pad_index;
                        run_next.run_length = tsct_pkg::RUN_SINGLE;
                    end
                    tsct_pkg::RUN_SINGLE: begin
                        if (left_adj) begin
                            run_next.right_pad  = run_cur.left_pad;
                            run_next.left_pad   = event_beat.pad_index;
                            run_next.run_length = tsct_pkg::RUN_DOUBLE;
                        end else if (pad_ext == (left_ext + 1'b1)) begin
                            run_next.right_pad  = event_beat.pad_index;
                            run_next.run_length = tsct_pkg::RUN_DOUBLE;
                        end else begin
                            run_next.left_pad = event_beat.pad_index;
                        end
                    end
                    tsct_pkg::RUN_DOUBLE: begin
                        if (left_adj) begin
                            run_next.middle_pad = run_cur.left_pad;
                            run_next.left_pad   = event_beat.pad_index;
                            run_next.run_length = tsct_pkg::RUN_TRIPLE;
                        end else if (right_adj) begin
                            run_next.middle_pad = run_cur.right_pad;
                            run_next.right_pad  = event_beat.pad_index;
                            run_next.run_length = tsct_pkg::RUN_TRIPLE;
                        end else begin
                            run_next.left_pad   = event_beat.pad_index;
                            run_next.run_length = tsct_pkg::RUN_SINGLE;
                        end
                    end
                    default: begin
                        // Triple: slide the window toward the new pad.
                        if (left_adj) begin
                            run_next.right_pad  = run_cur.middle_pad;
                            run_next.middle_pad = run_cur.left_pad;
                            run_next.left_pad   = event_beat.pad_index;
                        end else if (right_adj) begin
                            run_next.left_pad   = run_cur.middle_pad;
                            run_next.middle_pad = run_cur.right_pad;
                            run_next.right_pad  = event_beat.pad_index;
                        end else begin
                            run_next.left_pad   = event_beat.pad_index;
                            run_next.run_length = tsct_pkg::RUN_SINGLE;
                        end
                    end
                endcase
            end else begin
                case (run_cur.run_length)
                    tsct_pkg::RUN_SINGLE: begin
                        if (event_beat.pad_index == run_cur.left_pad) begin
                            run_next.run_length = tsct_pkg::RUN_EMPTY;
                        end
                    end
                    tsct_pkg::RUN_DOUBLE: begin
                        if (event_beat.pad_index == run_cur.left_pad) begin
                            run_next.left_pad   = run_cur.right_pad;
                            run_next.run_length = tsct_pkg::RUN_SINGLE;
                        end else if (event_beat.pad_index == run_cur.right_pad) begin
                            run_next.run_length = tsct_pkg::RUN_SINGLE;
                        end
                    end
                    tsct_pkg::RUN_TRIPLE: begin
                        // Releasing the middle pad keeps only the left pad.
                        if (event_beat.pad_index == run_cur.left_pad) begin
                            run_next.left_pad   = run_cur.middle_pad;
                            run_next.run_length = tsct_pkg::RUN_DOUBLE;
                        end else if (event_beat.pad_index == run_cur.right_pad) begin
                            run_next.right_pad  = run_cur.middle_pad;
                            run_next.run_length = tsct_pkg::RUN_DOUBLE;
                        end else if (event_beat.pad_index == run_cur.middle_pad) begin
                            run_next.run_length = tsct_pkg::RUN_SINGLE;
                        end
                    end
                    default: begin
                        run_next = run_cur;
                    end
                endcase
            end
        end
    end

    // Interpolated position of the updated run.
    assign pair_sum = {1'b0, run_next.left_pad} + {1'b0, run_next.right_pad};

    always_comb begin
        result.contact_count  = run_next.run_length;
        result.position_valid = (run_next.run_length != tsct_pkg::RUN_EMPTY);
        case (run_next.run_length)
            tsct_pkg::RUN_SINGLE: result.position = run_next.left_pad;
            tsct_pkg::RUN_DOUBLE: result.position = pair_sum[tsct_pkg::PAD_W:1];
            tsct_pkg::RUN_TRIPLE: result.position = run_next.middle_pad;
            default:              result.position = '0;
        endcase
    end

endmodule

### hw/rtl/touch_strip_contact_tracker.sv
// ----------------------------------------------------------------------------
// Touch strip contact tracker
// An event waits in the input register, its result in the result register.
// Throughput: one event per cycle while the result side accepts beats; the
// run update is a single pass of compares and moves between those two.
// Reset: aresetn (synchronous, active low) empties the run and both stages.
// ----------------------------------------------------------------------------
module touch_strip_contact_tracker (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  tsct_pkg::in_beat_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output tsct_pkg::out_beat_t m_data
);

    logic                in_valid_reg;
    tsct_pkg::in_beat_t  in_beat_reg;
    logic                out_valid_reg;
    tsct_pkg::out_beat_t out_beat_reg;
    tsct_pkg::run_t      run_reg;
    tsct_pkg::run_t      run_next;
    tsct_pkg::out_beat_t result_next;
    logic                advance;

    // The held event moves on when the result register is free or draining.
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    tsct_update u_update (
        .event_beat (in_beat_reg),
        .run_cur    (run_reg),
        .run_next   (run_next),
        .result     (result_next)
    );

    // Input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
        if (s_valid && s_ready) begin
            in_beat_reg <= s_data;
        end
    end

    // Run state, updated once per event.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg <= '0;
        end else if (advance) begin
            run_reg <= run_next;
        end
    end

    // Result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
        if (advance) begin
            out_beat_reg <= result_next;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_beat_reg;

endmodule

### dv/touch_strip_contact_tracker_checker.sv
// ----------------------------------------------------------------------------
// Touch strip contact tracker checker
// Watches both channels of the tracker, predicts the result beat of every
// accepted event from its own copy of the run, and compares each accepted
// result beat field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module touch_strip_contact_tracker_checker (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    input  logic                s_ready,
    input  tsct_pkg::in_beat_t  s_data,
    input  logic                m_valid,
    input  logic                m_ready,
    input  tsct_pkg::out_beat_t m_data,
    output int                  fail_count,
    output int                  pending_results
);
    timeunit 1ns;
    timeprecision 1ps;

    tsct_pkg::run_t      tracked_run;
    tsct_pkg::out_beat_t expected_positions[$];

    // Next run after one pad event. Adjacency is tested one bit wider than a
    // pad so that pad 31 and pad 0 are never taken for neighbors.
    function automatic tsct_pkg::run_t advance_run(tsct_pkg::run_t cur,
                                                   tsct_pkg::in_beat_t ev);
        tsct_pkg::run_t           nxt;
        logic [tsct_pkg::PAD_W:0] pad_w;
        logic [tsct_pkg::PAD_W:0] left_w;
        logic [tsct_pkg::PAD_W:0] right_w;
        logic                     left_adj;
        logic                     after_left;
        logic                     right_adj;
        nxt        = cur;
        pad_w      = {1'b0, ev.pad_index};
        left_w     = {1'b0, cur.left_pad};
        right_w    = {1'b0, cur.right_pad};
        left_adj   = (pad_w + 1'b1 == left_w);
        after_left = (pad_w == left_w + 1'b1);
        right_adj  = (pad_w == right_w + 1'b1);
        if (pad_w < tsct_pkg::NUM_PADS) begin
            if (ev.operation == tsct_pkg::OP_TOUCH) begin
                case (cur.run_length)
                    tsct_pkg::RUN_EMPTY: begin
                        nxt.left_pad   = ev.pad_index;
                        nxt.run_length = tsct_pkg::RUN_SINGLE;
                    end
                    tsct_pkg::RUN_SINGLE: begin
                        if (left_adj) begin
                            nxt.right_pad  = cur.left_pad;
                            nxt.left_pad   = ev.pad_index;
                            nxt.run_length = tsct_pkg::RUN_DOUBLE;
                        end else if (after_left) begin
                            nxt.right_pad  = ev.pad_index;
                            nxt.run_length = tsct_pkg::RUN_DOUBLE;
                        end else begin
                            nxt.left_pad = ev.pad_index;
                        end
                    end
                    tsct_pkg::RUN_DOUBLE: begin
                        if (left_adj) begin
                            nxt.middle_pad = cur.left_pad;
                            nxt.left_pad   = ev.pad_index;
                            nxt.run_length = tsct_pkg::RUN_TRIPLE;
                        end else if (right_adj) begin
                            nxt.middle_pad = cur.right_pad;
                            nxt.right_pad  = ev.pad_index;
                            nxt.run_length = tsct_pkg::RUN_TRIPLE;
                        end else begin
                            nxt.left_pad   = ev.pad_index;
                            nxt.run_length = tsct_pkg::RUN_SINGLE;
                        end
                    end
                    default: begin
                        // A triple slides toward the new pad and drops the far end.
                        if (left_adj) begin
                            nxt.right_pad  = cur.middle_pad;
                            nxt.middle_pad = cur.left_pad;
                            nxt.left_pad   = ev.pad_index;
                        end else if (right_adj) begin
                            nxt.left_pad   = cur.middle_pad;
                            nxt.middle_pad = cur.right_pad;
                            nxt.right_pad  = ev.pad_index;
                        end else begin
                            nxt.left_pad   = ev.pad_index;
                            nxt.run_length = tsct_pkg::RUN_SINGLE;
                        end
                    end
                endcase
            end else begin
                case (cur.run_length)
                    tsct_pkg::RUN_SINGLE: begin
                        if (ev.pad_index == cur.left_pad) begin
                            nxt.run_length = tsct_pkg::RUN_EMPTY;
                        end
                    end
                    tsct_pkg::RUN_DOUBLE: begin
                        if (ev.pad_index == cur.left_pad) begin
                            nxt.left_pad   = cur.right_pad;
                            nxt.run_length = tsct_pkg::RUN_SINGLE;
                        end else if (ev.pad_index == cur.right_pad) begin
                            nxt.run_length = tsct_pkg::RUN_SINGLE;
                        end
                    end
                    tsct_pkg::RUN_TRIPLE: begin
                        if (ev.pad_index == cur.left_pad) begin
                            nxt.left_pad   = cur.middle_pad;
                            nxt.run_length = tsct_pkg::RUN_DOUBLE;
                        end else if (ev.pad_index == cur.right_pad) begin
                            nxt.right_pad  = cur.middle_pad;
                            nxt.run_length = tsct_pkg::RUN_DOUBLE;
                        end else if (ev.pad_index == cur.middle_pad) begin
                            // Releasing the middle keeps only the left pad.
                            nxt.run_length = tsct_pkg::RUN_SINGLE;
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end
        return nxt;
    endfunction

    // Interpolated position of a run; a double takes the floor of the mean.
    function automatic tsct_pkg::out_beat_t position_of(tsct_pkg::run_t r);
        tsct_pkg::out_beat_t      beat;
        logic [tsct_pkg::PAD_W:0] pad_sum;
        pad_sum             = {1'b0, r.left_pad} + {1'b0, r.right_pad};
        beat.position_valid = (r.run_length != tsct_pkg::RUN_EMPTY);
        beat.contact_count  = r.run_length;
        case (r.run_length)
            tsct_pkg::RUN_SINGLE: beat.position = r.left_pad;
            tsct_pkg::RUN_DOUBLE: beat.position = pad_sum[tsct_pkg::PAD_W:1];
            tsct_pkg::RUN_TRIPLE: beat.position = r.middle_pad;
            default:              beat.position = '0;
        endcase
        return beat;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("%0t: tracker mismatch on %s: got %0d, want %0d", $realtime, what, got, want);
        fail_count++;
    endtask

    initial begin
        fail_count      = 0;
        pending_results = 0;
        tracked_run     = '0;
    end

    // Result beats are compared before the event of the same edge is
    // predicted: a result can never belong to an event accepted at that edge.
    always @(posedge aclk) begin
        tsct_pkg::out_beat_t want;
        if (!aresetn) begin
            tracked_run = '0;
            expected_positions.delete();
            pending_results = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_positions.size() == 0) begin
                    report_mismatch("unexpected result beat", int'(m_data), 0);
                end else begin
                    want = expected_positions.pop_front();
                    if (m_data.position !== want.position)
                        report_mismatch("position", int'(m_data.position),
                                        int'(want.position));
                    if (m_data.position_valid !== want.position_valid)
                        report_mismatch("position_valid", int'(m_data.position_valid),
                                        int'(want.position_valid));
                    if (m_data.contact_count !== want.contact_count)
                        report_mismatch("contact_count", int'(m_data.contact_count),
                                        int'(want.contact_count));
                end
            end
            if (s_valid && s_ready) begin
                tracked_run = advance_run(tracked_run, s_data);
                expected_positions.push_back(position_of(tracked_run));
            end
            pending_results = expected_positions.size();
        end
    end

endmodule

### dv/touch_strip_contact_tracker_tb.sv
// ----------------------------------------------------------------------------
// Touch strip contact tracker testbench
// Drives directed edge cases and then random local walks of touch and release
// events over the strip, with random idling on both channels, a long result
// back-pressure stretch and a drain pause. The checker beside the block does
// all prediction and comparison; this module gives the verdict.
// ----------------------------------------------------------------------------
module touch_strip_contact_tracker_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_EVENTS = 600;
    localparam int IDLE_PCT      = 14;
    localparam int HOLD_CYCLES   = 80;
    localparam int STALL_LIMIT   = 1000;
    localparam int DRAIN_CYCLES  = 10;

    logic                aclk;
    logic                aresetn;
    logic                s_valid;
    logic                s_ready;
    tsct_pkg::in_beat_t  s_data;
    logic                m_valid;
    logic                m_ready;
    tsct_pkg::out_beat_t m_data;

    int        fail_count;
    int        pending_results;

    logic      calm_stretch;
    logic      hold_request;
    logic      hold_done;
    int        quiet_cycles;

    touch_strip_contact_tracker i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    touch_strip_contact_tracker_checker i_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_data          (s_data),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_data          (m_data),
        .fail_count      (fail_count),
        .pending_results (pending_results)
    );

    // 10 ns clock.
    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    // Offers one event beat from a falling edge, with a random gap first, and
    // returns at the rising edge that accepts it.
    task automatic send_event(logic op, tsct_pkg::pad_t pad);
        @(negedge aclk);
        while (!calm_stretch && $urandom_range(0, 99) < IDLE_PCT) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid           <= 1'b1;
        s_data.operation  <= op;
        s_data.pad_index  <= pad;
        do begin
            @(posedge aclk);
        end while (!s_ready);
    endtask

    // Result side: random idling, one long hold-off while events keep coming.
    initial begin
        m_ready   = 1'b0;
        hold_done = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_request && !hold_done) begin
                hold_done = 1'b1;
                m_ready  <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge aclk);
            end else if (calm_stretch) begin
                m_ready <= 1'b1;
            end else begin
                m_ready <= ($urandom_range(0, 99) >= IDLE_PCT);
            end
        end
    end

    // Watchdog over cycles in which no beat moves on either channel.
    initial begin
        quiet_cycles = 0;
        while (quiet_cycles < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("touch_strip_contact_tracker verification failed");
        $finish;
    end

    // Reset, directed events, random walks, drain and verdict.
    initial begin
        int             anchor;
        int             offset;
        int             pick;
        logic           op;
        tsct_pkg::pad_t pad;
        aresetn      = 1'b0;
        s_valid      = 1'b0;
        s_data       = '0;
        calm_stretch = 1'b0;
        hold_request = 1'b0;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Directed: empty release, edge pads, growth, slides, restarts,
        // middle release and the no-wrap neighbors at both strip ends.
        send_event(tsct_pkg::OP_RELEASE, 5'd5);
        send_event(tsct_pkg::OP_TOUCH,   5'd0);
        send_event(tsct_pkg::OP_TOUCH,   5'd0);
        send_event(tsct_pkg::OP_TOUCH,   5'd1);
        send_event(tsct_pkg::OP_TOUCH,   5'd2);
        send_event(tsct_pkg::OP_TOUCH,   5'd3);
        send_event(tsct_pkg::OP_TOUCH,   5'd0);
        send_event(tsct_pkg::OP_TOUCH,   5'd1);
        send_event(tsct_pkg::OP_TOUCH,   5'd0);
        send_event(tsct_pkg::OP_RELEASE, 5'd1);
        send_event(tsct_pkg::OP_TOUCH,   5'd31);
        send_event(tsct_pkg::OP_TOUCH,   5'd30);
        send_event(tsct_pkg::OP_TOUCH,   5'd29);
        send_event(tsct_pkg::OP_RELEASE, 5'd30);
        send_event(tsct_pkg::OP_TOUCH,   5'd30);
        send_event(tsct_pkg::OP_TOUCH,   5'd31);
        send_event(tsct_pkg::OP_RELEASE, 5'd29);
        send_event(tsct_pkg::OP_TOUCH,   5'd29);
        send_event(tsct_pkg::OP_RELEASE, 5'd31);
        send_event(tsct_pkg::OP_RELEASE, 5'd29);
        send_event(tsct_pkg::OP_RELEASE, 5'd7);
        send_event(tsct_pkg::OP_RELEASE, 5'd30);
        send_event(tsct_pkg::OP_TOUCH,   5'd0);
        send_event(tsct_pkg::OP_TOUCH,   5'd31);
        send_event(tsct_pkg::OP_TOUCH,   5'd0);

        // Random: mostly a walk around an anchor pad so runs grow, slide and
        // shrink; the rest is noise anywhere on the strip.
        anchor = int'($urandom_range(0, tsct_pkg::NUM_PADS - 1));
        for (int n = 0; n < RANDOM_EVENTS; n++) begin
            calm_stretch = (n >= 250 && n < 370);
            if (n == 150)
                hold_request = 1'b1;
            if (n == 450) begin
                @(negedge aclk);
                s_valid <= 1'b0;
                wait (pending_results == 0);
            end
            pick = int'($urandom_range(0, 99));
            if (pick < 5) begin
                anchor = ($urandom_range(0, 1) == 1) ? tsct_pkg::NUM_PADS - 1 : 0;
            end else if (pick < 10) begin
                anchor = int'($urandom_range(0, tsct_pkg::NUM_PADS - 1));
            end
            if (pick >= 80) begin
                op  = 1'($urandom_range(0, 1));
                pad = tsct_pkg::PAD_W'($urandom_range(0, tsct_pkg::NUM_PADS - 1));
            end else begin
                op     = ($urandom_range(0, 99) < 35) ? tsct_pkg::OP_RELEASE
                                                      : tsct_pkg::OP_TOUCH;
                offset = anchor + int'($urandom_range(0, 4)) - 2;
                if (offset < 0)
                    offset = 0;
                if (offset > tsct_pkg::NUM_PADS - 1)
                    offset = tsct_pkg::NUM_PADS - 1;
                pad = tsct_pkg::PAD_W'(offset);
                if (op == tsct_pkg::OP_TOUCH && $urandom_range(0, 1) == 1)
                    anchor = offset;
            end
            send_event(op, pad);
        end
        calm_stretch = 1'b0;

        @(negedge aclk);
        s_valid <= 1'b0;
        wait (pending_results == 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (fail_count == 0)
            $display("touch_strip_contact_tracker verification clean");
        else
            $display("touch_strip_contact_tracker verification failed");
        $finish;
    end

endmodule
